### design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Field widths of one beat
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CountW = 5;

  // Operation codes
  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL_DROP = 2'd1,
    STATUS_EMPTY_DEQ = 2'd2
  } status_e;

  // One result beat as produced by the slot array
  typedef struct packed {
    logic signed [ValueW-1:0] top_value;
    logic signed [PrioW-1:0]  top_priority;
    logic                     is_empty;
    logic [CountW-1:0]        entry_count;
    status_e                  status;
  } result_t;

endpackage

`default_nettype wire

### design/spq_req_if.sv
// Request channel: enqueue/dequeue command with its entry.
`default_nettype none

interface spq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [spq_pkg::ValueW-1:0]   value;
  logic signed [spq_pkg::PrioW-1:0]    priority_req;

  modport source (output valid, output op, output value, output priority_req, input ready);
  modport sink   (input valid, input op, input value, input priority_req, output ready);
endinterface

`default_nettype wire

### design/spq_rsp_if.sv
// Response channel: top entry, empty flag, count and status.
`default_nettype none

interface spq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [spq_pkg::ValueW-1:0]   top_value;
  logic signed [spq_pkg::PrioW-1:0]    top_priority;
  logic                                is_empty;
  logic [spq_pkg::CountW-1:0]          entry_count;
  logic [1:0]                          status;

  modport source (output valid, output top_value, output top_priority, output is_empty,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input top_value, input top_priority, input is_empty,
                  input entry_count, input status, output ready);
endinterface

`default_nettype wire

### design/spq_slot_array.sv
// Sorted slot storage with parallel compare and a shift of the whole list on insert or remove.
`default_nettype none

module spq_slot_array #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              op_i,
  input  wire logic signed [spq_pkg::ValueW-1:0] value_i,
  input  wire logic signed [spq_pkg::PrioW-1:0]  priority_i,
  output spq_pkg::result_t                       result_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic signed [spq_pkg::ValueW-1:0] val_q  [DEPTH];
  logic signed [spq_pkg::PrioW-1:0]  prio_q [DEPTH];
  logic signed [spq_pkg::ValueW-1:0] val_d  [DEPTH];
  logic signed [spq_pkg::PrioW-1:0]  prio_d [DEPTH];
  logic [CntW-1:0]                   occ_q, occ_d;

  logic [DEPTH-1:0] keep;
  logic             is_enq, full, empty, write_en;
  logic [CntW+spq_pkg::CountW-1:0] count_wide;

  assign is_enq   = (op_i == spq_pkg::OP_ENQUEUE);
  assign full     = (occ_q == CntW'(DEPTH));
  assign empty    = (occ_q == '0);
  assign write_en = accept_i && (is_enq ? !full : !empty);

  // Mark slots that hold their entry on enqueue (higher priority, top kept on tie)
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_slot
      if (g == 0) begin : g_top
        assign keep[g] = !empty && (prio_q[g] >= priority_i);
        assign val_d[g]  = !is_enq ? val_q[g+1] :
                           keep[g] ? val_q[g] : value_i;
        assign prio_d[g] = !is_enq ? prio_q[g+1] :
                           keep[g] ? prio_q[g] : priority_i;
      end else begin : g_rest
        logic in_use;
        assign in_use  = (CntW'(g) < occ_q);
        assign keep[g] = in_use && (prio_q[g] > priority_i);
        if (g == DEPTH - 1) begin : g_last
          assign val_d[g]  = !is_enq ? val_q[g] :
                             keep[g] ? val_q[g] : keep[g-1] ? value_i : val_q[g-1];
          assign prio_d[g] = !is_enq ? prio_q[g] :
                             keep[g] ? prio_q[g] : keep[g-1] ? priority_i : prio_q[g-1];
        end else begin : g_mid
          assign val_d[g]  = !is_enq ? val_q[g+1] :
                             keep[g] ? val_q[g] : keep[g-1] ? value_i : val_q[g-1];
          assign prio_d[g] = !is_enq ? prio_q[g+1] :
                             keep[g] ? prio_q[g] : keep[g-1] ? priority_i : prio_q[g-1];
        end
      end
    end
  endgenerate

  // Count update
  always_comb begin
    occ_d = occ_q;
    if (write_en) begin
      occ_d = is_enq ? occ_q + CntW'(1) : occ_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Shift the whole list on each enabled write
  always_ff @(posedge clk_i) begin
    if (write_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        val_q[i]  <= val_d[i];
        prio_q[i] <= prio_d[i];
      end
    end
  end

  // Build the result from the state after this beat
  assign count_wide = {{spq_pkg::CountW{1'b0}}, occ_d};

  always_comb begin
    result_o.is_empty     = (occ_d == '0);
    result_o.entry_count  = count_wide[spq_pkg::CountW-1:0];
    result_o.top_value    = '0;
    result_o.top_priority = '0;
    if (occ_d != '0) begin
      result_o.top_value    = write_en ? val_d[0] : val_q[0];
      result_o.top_priority = write_en ? prio_d[0] : prio_q[0];
    end
    if (is_enq && full) begin
      result_o.status = spq_pkg::STATUS_FULL_DROP;
    end else if (!is_enq && empty) begin
      result_o.status = spq_pkg::STATUS_EMPTY_DEQ;
    end else begin
      result_o.status = spq_pkg::STATUS_DONE;
    end
  end

endmodule

`default_nettype wire

### design/spq_result_reg.sv
// Output register for result beats with valid/ready handshake.
`default_nettype none

module spq_result_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire spq_pkg::result_t result_i,
  output logic                  can_load_o,
  spq_rsp_if.source             rsp_o
);

  logic             valid_q, valid_d;
  spq_pkg::result_t data_q;

  // Free when empty or the held beat leaves this cycle
  assign can_load_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until a new beat replaces it
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.top_value    = data_q.top_value;
  assign rsp_o.top_priority = data_q.top_priority;
  assign rsp_o.is_empty     = data_q.is_empty;
  assign rsp_o.entry_count  = data_q.entry_count;
  assign rsp_o.status       = data_q.status;

endmodule

`default_nettype wire

### design/sorted_priority_queue_core.sv
// Result: a result beat is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while rsp_o drains; the compare-and-shift
//   across all slots completes in the same cycle, and the output register frees
//   as it drains. Reset: clears the entry count and the result valid; slot
//   contents are not cleared, since only slots below the count are ever read.
// Top level of the sorted priority queue.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  spq_req_if.sink      req_i,
  spq_rsp_if.source    rsp_o
);

  logic             accept;
  logic             can_load;
  spq_pkg::result_t result;

  // Take a request whenever the output register has room
  assign req_i.ready = can_load;
  assign accept      = req_i.valid && can_load;

  spq_slot_array #(
    .DEPTH(DEPTH)
  ) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (req_i.op),
    .value_i    (req_i.value),
    .priority_i (req_i.priority_req),
    .result_o   (result)
  );

  spq_result_reg u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .result_i   (result),
    .can_load_o (can_load),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire
